>>> sv/ledit_pkg.sv
// ---------------------------------------------------------------------------
// ledit_pkg
// Request codes, keystroke codes and status codes of the line edit buffer.
// ---------------------------------------------------------------------------
package ledit_pkg;

  typedef enum logic [2:0] {
    REQ_KEY     = 3'd0,
    REQ_START   = 3'd1,
    REQ_PRELOAD = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_READ    = 3'd4
  } req_e;

  localparam logic [2:0] ST_EDITING      = 3'd0;
  localparam logic [2:0] ST_COMMIT_DOWN  = 3'd1;
  localparam logic [2:0] ST_COMMIT_RIGHT = 3'd2;
  localparam logic [2:0] ST_COMMIT_LEFT  = 3'd3;
  localparam logic [2:0] ST_COMMIT_UP    = 3'd4;
  localparam logic [2:0] ST_CANCEL       = 3'd5;

  localparam logic [7:0] KEY_RETURN    = 8'h0D;
  localparam logic [7:0] KEY_TAB       = 8'h09;
  localparam logic [7:0] KEY_SHIFT_TAB = 8'h18;
  localparam logic [7:0] KEY_UP        = 8'h91;
  localparam logic [7:0] KEY_DOWN      = 8'h11;
  localparam logic [7:0] KEY_ESCAPE    = 8'h1B;
  localparam logic [7:0] KEY_BACKSPACE = 8'h14;
  localparam logic [7:0] KEY_DELETE    = 8'h19;
  localparam logic [7:0] KEY_LEFT      = 8'h9D;
  localparam logic [7:0] KEY_RIGHT     = 8'h1D;
  localparam logic [7:0] KEY_HOME      = 8'h13;
  localparam logic [7:0] KEY_END       = 8'h04;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_TILDE     = 8'h7E;

  localparam logic [7:0] CHAR_NUL      = 8'h00;

endpackage

>>> sv/line_edit_buffer.sv
// ---------------------------------------------------------------------------
// line_edit_buffer
// Single-line text editor with a caret, kept in a character RAM.
// ---------------------------------------------------------------------------
// Usage: the input channel carries one request word (req_type_i, key_code_i,
// read_index_i), qualified by in_valid_i and held off by in_stall_o. Every
// request yields exactly one result word on the output channel (status_o,
// text_length_o, caret_pos_o, is_active_o, read_char_o), qualified by
// out_valid_o and held off by out_stall_i.
// Most requests go straight to S_FINISH, from which the result is loaded into
// the output register; a read inside the line passes S_RD_WAIT first, and an
// insertion in the middle of the line or a deletion that is not the last
// character passes the move states S_MV_RD and S_MV_WR first (and S_PUT for
// an insertion). The character RAM has a single read and a single write
// port, so each moved character is read in S_MV_RD and written in S_MV_WR.
// One request is in work at a time; the finished result waits in the output
// register while the next request is taken.
// When the receiver stalls, the result word holds; a further finished result
// waits inside the block, which then stalls its input.
// Reset clears length, caret, active flag and the output valid flag; the
// character RAM is not cleared and only positions below the length are read.
// ---------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int LINE_CAP = 80
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] key_code_i,
  input  logic [6:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [6:0] text_length_o,
  output logic [6:0] caret_pos_o,
  output logic       is_active_o,
  output logic [7:0] read_char_o
);
  import ledit_pkg::*;

  localparam int AW  = $clog2(LINE_CAP);
  localparam int LW  = $clog2(LINE_CAP + 1);
  localparam int LW1 = LW + 1;
  localparam int CW  = (LW > 7) ? LW : 7;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MV_RD   = 6'b000010,
    S_MV_WR   = 6'b000100,
    S_PUT     = 6'b001000,
    S_RD_WAIT = 6'b010000,
    S_FINISH  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] caret_q, caret_d;
  logic          active_q, active_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          dir_ins_q, dir_ins_d;
  logic          bs_q, bs_d;
  logic [7:0]    ch_q, ch_d;
  logic [2:0]    status_q, status_d;
  logic [7:0]    rdch_q, rdch_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q;
  logic [6:0]    out_len_q;
  logic [6:0]    out_caret_q;
  logic          out_active_q;
  logic [7:0]    out_char_q;
  logic          out_load;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic          in_acc;
  logic          len_full;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] caret_ext;
  logic [CW-1:0] idx_ext;

  ledit_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAP)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign len_full   = (len_q == LW'(LINE_CAP));
  assign len_ext    = CW'(len_q);
  assign caret_ext  = CW'(caret_q);
  assign idx_ext    = CW'(read_index_i);

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    caret_d   = caret_q;
    active_d  = active_q;
    ptr_d     = ptr_q;
    dir_ins_d = dir_ins_q;
    bs_d      = bs_q;
    ch_d      = ch_q;
    status_d  = status_q;
    rdch_d    = rdch_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          status_d = ST_EDITING;
          rdch_d   = '0;
          state_d  = S_FINISH;
          case (req_type_i)
            REQ_KEY: begin
              if (active_q) begin
                case (key_code_i)
                  KEY_RETURN, KEY_DOWN: status_d = ST_COMMIT_DOWN;
                  KEY_TAB:              status_d = ST_COMMIT_RIGHT;
                  KEY_SHIFT_TAB:        status_d = ST_COMMIT_LEFT;
                  KEY_UP:               status_d = ST_COMMIT_UP;
                  KEY_ESCAPE:           status_d = ST_CANCEL;
                  KEY_BACKSPACE: begin
                    if (caret_q != '0) begin
                      if (caret_q < len_q) begin
                        // Close the gap left of the caret, then step back.
                        ptr_d     = AW'(caret_q - LW'(1));
                        dir_ins_d = 1'b0;
                        bs_d      = 1'b1;
                        state_d   = S_MV_RD;
                      end else begin
                        len_d   = len_q - LW'(1);
                        caret_d = caret_q - LW'(1);
                      end
                    end
                  end
                  KEY_DELETE: begin
                    if (caret_q < len_q) begin
                      if ((LW1'(caret_q) + LW1'(1)) < LW1'(len_q)) begin
                        ptr_d     = AW'(caret_q);
                        dir_ins_d = 1'b0;
                        bs_d      = 1'b0;
                        state_d   = S_MV_RD;
                      end else begin
                        len_d = len_q - LW'(1);
                      end
                    end
                  end
                  KEY_LEFT: begin
                    if (caret_q != '0) begin
                      caret_d = caret_q - LW'(1);
                    end
                  end
                  KEY_RIGHT: begin
                    if (caret_q < len_q) begin
                      caret_d = caret_q + LW'(1);
                    end
                  end
                  KEY_HOME: caret_d = '0;
                  KEY_END:  caret_d = len_q;
                  default: begin
                    if ((key_code_i inside {[KEY_SPACE:KEY_TILDE]}) && !len_full) begin
                      ch_d = key_code_i;
                      if (caret_q == len_q) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(caret_q);
                        mem_wdata = key_code_i;
                        len_d     = len_q + LW'(1);
                        caret_d   = caret_q + LW'(1);
                      end else begin
                        // Open a gap at the caret from the end of the line.
                        ptr_d     = AW'(len_q - LW'(1));
                        dir_ins_d = 1'b1;
                        state_d   = S_MV_RD;
                      end
                    end
                  end
                endcase
              end
            end
            REQ_START: begin
              len_d    = '0;
              caret_d  = '0;
              active_d = 1'b1;
            end
            REQ_PRELOAD: begin
              if ((key_code_i != CHAR_NUL) && !len_full) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(len_q);
                mem_wdata = key_code_i;
                len_d     = len_q + LW'(1);
                caret_d   = len_q + LW'(1);
              end else begin
                caret_d = len_q;
              end
            end
            REQ_STOP: begin
              len_d    = '0;
              caret_d  = '0;
              active_d = 1'b0;
            end
            REQ_READ: begin
              if (idx_ext < len_ext) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(read_index_i);
                state_d   = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = dir_ins_q ? ptr_q : ptr_q + AW'(1);
        state_d   = S_MV_WR;
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dir_ins_q ? ptr_q + AW'(1) : ptr_q;
        mem_wdata = mem_rdata;
        if (dir_ins_q) begin
          if (LW'(ptr_q) == caret_q) begin
            state_d = S_PUT;
          end else begin
            ptr_d   = ptr_q - AW'(1);
            state_d = S_MV_RD;
          end
        end else begin
          if ((LW1'(ptr_q) + LW1'(2)) >= LW1'(len_q)) begin
            len_d = len_q - LW'(1);
            if (bs_q) begin
              caret_d = caret_q - LW'(1);
            end
            state_d = S_FINISH;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = S_MV_RD;
          end
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(caret_q);
        mem_wdata = ch_q;
        len_d     = len_q + LW'(1);
        caret_d   = caret_q + LW'(1);
        state_d   = S_FINISH;
      end
      S_RD_WAIT: begin
        rdch_d  = mem_rdata;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      caret_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      caret_q     <= caret_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    dir_ins_q <= dir_ins_d;
    bs_q      <= bs_d;
    ch_q      <= ch_d;
    status_q  <= status_d;
    rdch_q    <= rdch_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_len_q    <= len_ext[6:0];
      out_caret_q  <= caret_ext[6:0];
      out_active_q <= active_q;
      out_char_q   <= rdch_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign text_length_o = out_len_q;
  assign caret_pos_o   = out_caret_q;
  assign is_active_o   = out_active_q;
  assign read_char_o   = out_char_q;

`ifndef SYNTHESIS
  // The caret never leaves the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni) caret_q <= len_q)
    else $error("caret past the end of the line");

  // The line never grows beyond its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LW'(LINE_CAP))
    else $error("line length above capacity");

  // Writes stay inside the character store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (LW'(mem_waddr) < LW'(LINE_CAP)))
    else $error("character store written out of range");

  // Every accepted request is still in work in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> state_q != S_IDLE)
    else $error("request lost on acceptance");

  // Placing the inserted character always completes the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |=> state_q == S_FINISH)
    else $error("insertion did not complete");
`endif

endmodule

>>> sv/ledit_ram.sv
// ---------------------------------------------------------------------------
// ledit_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module ledit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
